FILE: sv/itoar_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the integer-to-ASCII block.
// Used by itoar_ctrl, itoar_dp and the integer_to_ascii_radix top level.
package itoar_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int RADIX_W       = 6;
  localparam int IDX_W         = $clog2(VALUE_WIDTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = VALUE_WIDTH / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);
  localparam int ADDR_W        = 2;
  localparam int DATA_W        = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [ADDR_W-1:0] REG_RADIX_ADDR = '0;

  localparam logic [7:0] MINUS_CODE      = 8'h2d;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;
  localparam logic [7:0] EMPTY_CODE      = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic rd_issue;
    logic emit_digit;
    logic emit_empty;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radix_ok;
    logic div_done;
    logic negative;
    logic out_free;
    logic last_digit;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] d8;
    d8 = {{(8-RADIX_W){1'b0}}, d};
    if (d < RADIX_W'(10)) begin
      return CHAR_ZERO + d8;
    end else begin
      return CHAR_ALPHA_BASE + d8;
    end
  endfunction

endpackage

FILE: sv/itoar_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the integer-to-ASCII block.
// Depends on itoar_pkg; drives commands into itoar_dp and reads its status.
module itoar_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  itoar_pkg::sts_t  sts,
  output itoar_pkg::cmd_t  cmd
);
  import itoar_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SIGN  = 6'b000100,
    S_READ  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.radix_ok) begin
            cmd.load = 1'b1;
            state_next = S_DIV;
          end else begin
            state_next = S_EMPTY;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = sts.negative ? S_SIGN : S_READ;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next = sts.last_digit ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_sign, cmd.emit_digit, cmd.emit_empty}))
    else $error("more than one character transfer commanded in one cycle");

  a_emit_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (state == S_EMIT) && $past(state == S_READ || state == S_EMIT))
    else $error("digit emitted without a preceding store read");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || (in_valid && !in_stall)) |=> (state != S_IDLE))
    else $error("accepted item did not start work");

endmodule

FILE: sv/itoar_dp.sv
`timescale 1ns / 1ps
// Datapath: magnitude/sign capture, radix divider (four quotient bits per
// cycle), digit store, and the result output register. Depends on itoar_pkg.
module itoar_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [itoar_pkg::RADIX_W-1:0]            radix,
  input  logic signed [itoar_pkg::VALUE_WIDTH-1:0] value,
  input  itoar_pkg::cmd_t                          cmd,
  output itoar_pkg::sts_t                          sts,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [7:0]                               char_code,
  output logic                                     is_last,
  output logic                                     is_empty
);
  import itoar_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quotient;
  logic [RADIX_W-1:0]     rem_r;
  logic [STEP_W-1:0]      step_cnt;
  logic [CNT_W-1:0]       digit_count;
  logic                   negative_flag;
  logic [RADIX_W-1:0]     rd_data;
  logic [RADIX_W-1:0]     digit_store [VALUE_WIDTH];

  logic [VALUE_WIDTH-1:0] value_u;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [VALUE_WIDTH-1:0] q_step;
  logic [RADIX_W-1:0]     r_step;
  logic                   step_last;
  logic [CNT_W-1:0]       count_dec;
  logic                   out_free;

  assign value_u   = value;
  assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
  assign step_last = (step_cnt == STEP_LAST);
  assign count_dec = digit_count - CNT_W'(1);
  assign out_free  = !out_valid || !out_stall;

  // Restoring division: shift the quotient's top bit into the remainder,
  // subtract the radix where it fits, and shift the result bit back in.
  always_comb begin
    logic [RADIX_W:0] r7;
    logic             ge;
    q_step = quotient;
    r_step = rem_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      r7 = {r_step, q_step[VALUE_WIDTH-1]};
      ge = (r7 >= {1'b0, radix});
      q_step = {q_step[VALUE_WIDTH-2:0], ge};
      r_step = ge ? RADIX_W'(r7 - {1'b0, radix}) : r7[RADIX_W-1:0];
    end
  end

  assign sts.radix_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign sts.div_done   = step_last && ((q_step == '0) || (digit_count == CNT_FULL - CNT_W'(1)));
  assign sts.negative   = negative_flag;
  assign sts.out_free   = out_free;
  assign sts.last_digit = (digit_count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient      <= '0;
      rem_r         <= '0;
      step_cnt      <= '0;
      digit_count   <= '0;
      negative_flag <= 1'b0;
    end else begin
      if (cmd.load) begin
        quotient      <= magnitude;
        negative_flag <= value_u[VALUE_WIDTH-1];
        rem_r         <= '0;
        step_cnt      <= '0;
        digit_count   <= '0;
      end else if (cmd.div_step) begin
        quotient <= q_step;
        if (step_last) begin
          rem_r       <= '0;
          step_cnt    <= '0;
          digit_count <= digit_count + CNT_W'(1);
        end else begin
          rem_r    <= r_step;
          step_cnt <= step_cnt + STEP_W'(1);
        end
      end else if (cmd.emit_digit) begin
        digit_count <= count_dec;
      end
    end
  end

  // Digit store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_step && step_last) begin
      digit_store[digit_count[IDX_W-1:0]] <= r_step;
    end
    if (cmd.rd_issue) begin
      rd_data <= digit_store[count_dec[IDX_W-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_code <= MINUS_CODE;
      is_last   <= 1'b0;
      is_empty  <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= digit_char(rd_data);
      is_last   <= sts.last_digit;
      is_empty  <= 1'b0;
    end else if (cmd.emit_empty) begin
      char_code <= EMPTY_CODE;
      is_last   <= 1'b1;
      is_empty  <= 1'b0 | 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_FULL)
    else $error("digit count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (digit_count != '0))
    else $error("digit emitted from an empty store");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem_r < radix) && (r_step < radix))
    else $error("division remainder not below radix");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit || cmd.emit_empty) |-> out_free)
    else $error("output register loaded while a result is held");

endmodule

FILE: sv/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// Top level of the integer-to-ASCII converter: configuration register port,
// controller and datapath. Depends on itoar_pkg, itoar_ctrl and itoar_dp.

// Converts one signed 32-bit value to ASCII text in the base held in the radix
// register (byte address 0, reset 10); digits are 0-9 then a-z, a negative value
// starts with '-', and characters leave most significant first with is_last on
// the final one. A radix outside 2 to 36 gives a single transfer with is_empty
// and is_last set and char_code 0. One item is worked on at a time. The divider
// retires four quotient bits per cycle and finds one digit per pass; after the
// division comes a minus sign for a negative value, then for each digit a read
// of the digit store and a load of the output register, which out_stall can hold.
module integer_to_ascii_radix (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [itoar_pkg::ADDR_W-1:0]             paddr,
  input  logic [itoar_pkg::DATA_W-1:0]             pwdata,
  output logic [itoar_pkg::DATA_W-1:0]             prdata,
  output logic                                     pready,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [itoar_pkg::VALUE_WIDTH-1:0] value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [7:0]                               char_code,
  output logic                                     is_last,
  output logic                                     is_empty
);
  import itoar_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic               cfg_write;
  cmd_t               cmd;
  sts_t               sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write && (paddr == REG_RADIX_ADDR)) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_RADIX_ADDR) begin
      prdata = {{(DATA_W-RADIX_W){1'b0}}, radix};
    end
  end

  itoar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoar_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .is_last   (is_last),
    .is_empty  (is_empty)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_radix: directed table, then random phases.
// Depends on itoar_pkg and the integer_to_ascii_radix RTL; expected text comes from the
// literal strings of the directed table or from a conversion routine kept inside this file.
module tb_top;
  import itoar_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 40;
  localparam int PRINT_LIMIT   = 50;

  typedef enum {ROW_PREDICT, ROW_TEXT, ROW_EMPTY} row_kind_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       empty;
  } char_result_t;

  typedef struct {
    logic [RADIX_W-1:0]     base;
    logic [VALUE_WIDTH-1:0] v;
    row_kind_t              kind;
    string                  text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VALUE_WIDTH-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] char_code;
  logic is_last;
  logic is_empty;

  char_result_t       pending_chars[$];
  stim_row_t          stimulus_rows[$];
  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  int                 error_count = 0;
  int                 quiet_cycles = 0;
  int                 burst_left = 0;
  int                 stall_left = 0;
  int                 stall_tick = 0;
  stall_mode_t        stall_mode = STALL_NONE;

  integer_to_ascii_radix DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .char_code(char_code), .is_last(is_last), .is_empty(is_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Converts v in the given base the way the block should: the digits come from the
  // unsigned magnitude, so the most negative value needs no special handling.
  function automatic void convert_value(input logic [VALUE_WIDTH-1:0] v,
                                        input logic [RADIX_W-1:0] base);
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_W-1:0]     digits[$];
    logic [RADIX_W-1:0]     d;
    char_result_t           r;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      r = '{code: EMPTY_CODE, last: 1'b1, empty: 1'b1};
      pending_chars.push_back(r);
      return;
    end
    mag = v[VALUE_WIDTH-1] ? ~v + 1'b1 : v;
    do begin
      digits.push_front(RADIX_W'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (v[VALUE_WIDTH-1]) begin
      r = '{code: MINUS_CODE, last: 1'b0, empty: 1'b0};
      pending_chars.push_back(r);
    end
    while (digits.size() != 0) begin
      d = digits.pop_front();
      r.code  = (d < 10) ? 8'h30 + 8'(d) : 8'h61 + 8'(d) - 8'd10;
      r.last  = (digits.size() == 0);
      r.empty = 1'b0;
      pending_chars.push_back(r);
    end
  endfunction

  function automatic void push_text(input string s);
    char_result_t r;
    for (int i = 0; i < s.len(); i++) begin
      r = '{code: s[i], last: (i == s.len() - 1), empty: 1'b0};
      pending_chars.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic [RADIX_W-1:0] base,
                                  input logic [VALUE_WIDTH-1:0] v,
                                  input row_kind_t kind, input string text);
    stim_row_t row;
    row.base = base;
    row.v    = v;
    row.kind = kind;
    row.text = text;
    stimulus_rows.push_back(row);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [RADIX_W-1:0] base);
    logic [VALUE_WIDTH-1:0] v;
    longint unsigned        p;
    int                     b;
    int                     k;
    int                     sel;
    b = (base < RADIX_MIN) ? 10 : int'(base);
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, b * b);
      6: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '1;
          3: v = '0;
          default: v = 32'd1;
        endcase
      end
      // Values next to a power of the base change the digit count by one.
      7, 8: begin
        p = b;
        k = $urandom_range(0, 31);
        while (k > 0 && p * b < 64'h8000_0000) begin
          p = p * b;
          k--;
        end
        v = VALUE_WIDTH'(p) + VALUE_WIDTH'($urandom_range(0, 2)) - 1'b1;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (sel >= 4 && sel != 6 && $urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix(input int phase);
    case (phase)
      0: return RADIX_W'(2);
      1: return RADIX_W'(36);
      2: return RADIX_W'(7);
      3: return RADIX_W'(16);
      default: begin
        if ($urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 4))
            0: return RADIX_W'(0);
            1: return RADIX_W'(1);
            2: return RADIX_W'(37);
            3: return RADIX_W'(63);
            default: return RADIX_W'($urandom_range(37, 63));
          endcase
        end
        return RADIX_W'($urandom_range(2, 36));
      end
    endcase
  endfunction

  // Presents one value and holds it until the transfer; valid stays high afterwards
  // so that the next value can follow without a bubble.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input row_kind_t kind,
                            input string text);
    int gap;
    char_result_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    case (kind)
      ROW_TEXT: push_text(text);
      ROW_EMPTY: begin
        r = '{code: EMPTY_CODE, last: 1'b1, empty: 1'b1};
        pending_chars.push_back(r);
      end
      default: convert_value(v, radix_setting);
    endcase
  endtask

  task automatic drain_block;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_RADIX_ADDR;
    pwdata <= DATA_W'(r);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    radix_setting = r;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic change_radix(input logic [RADIX_W-1:0] r);
    drain_block();
    write_radix(r);
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    char_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("transfer with nothing pending: char_code %02h last %b",
                                  char_code, is_last));
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code)
          report_mismatch($sformatf("char_code %02h, wanted %02h", char_code, want.code));
        if (is_last !== want.last)
          report_mismatch($sformatf("is_last %b, wanted %b", is_last, want.last));
        if (is_empty !== want.empty)
          report_mismatch($sformatf("is_empty %b, wanted %b", is_empty, want.empty));
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] base;
    add_row(6'd10, 32'd0, ROW_TEXT, "0");
    add_row(6'd10, 32'd2147483647, ROW_TEXT, "2147483647");
    add_row(6'd10, 32'h8000_0000, ROW_TEXT, "-2147483648");
    add_row(6'd10, 32'hffff_ffff, ROW_TEXT, "-1");
    add_row(6'd10, 32'd9, ROW_TEXT, "9");
    add_row(6'd2, 32'h8000_0000, ROW_PREDICT, "");
    add_row(6'd2, 32'hffff_ffff, ROW_TEXT, "-1");
    add_row(6'd2, 32'h7fff_ffff, ROW_PREDICT, "");
    add_row(6'd2, 32'h5555_5555, ROW_PREDICT, "");
    add_row(6'd36, 32'd35, ROW_TEXT, "z");
    add_row(6'd36, -32'sd36, ROW_TEXT, "-10");
    add_row(6'd36, 32'h7fff_ffff, ROW_PREDICT, "");
    add_row(6'd36, 32'h8000_0000, ROW_PREDICT, "");
    add_row(6'd16, 32'hdead_beef, ROW_PREDICT, "");
    add_row(6'd16, 32'd255, ROW_TEXT, "ff");
    add_row(6'd16, 32'h7fff_ffff, ROW_TEXT, "7fffffff");
    add_row(6'd16, 32'h8000_0000, ROW_TEXT, "-80000000");
    add_row(6'd0, 32'd123, ROW_EMPTY, "");
    add_row(6'd1, -32'sd5, ROW_EMPTY, "");
    add_row(6'd37, 32'd0, ROW_EMPTY, "");
    add_row(6'd63, 32'h8000_0000, ROW_EMPTY, "");
    add_row(6'd3, 32'd0, ROW_TEXT, "0");
    add_row(6'd8, -32'sd8, ROW_TEXT, "-10");
    add_row(6'd35, 32'd34, ROW_TEXT, "y");
    add_row(6'd10, 32'd1234567890, ROW_TEXT, "1234567890");

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stimulus_rows[i]) begin
      if (stimulus_rows[i].base != radix_setting) begin
        change_radix(stimulus_rows[i].base);
      end
      send_value(stimulus_rows[i].v, stimulus_rows[i].kind, stimulus_rows[i].text);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      base = pick_radix(phase);
      change_radix(base);
      repeat (PHASE_ITEMS) send_value(pick_value(base), ROW_PREDICT, "");
    end

    drain_block();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/itoar_pkg.sv
sv/itoar_ctrl.sv
sv/itoar_dp.sv
sv/integer_to_ascii_radix.sv
verif/tb_top.sv
